// File: hdl/sbp_pkg.sv
// Package for the segmented buffer packer: widths, reset values, register
// indexes and the types shared between the top level and the add/sub unit.
// No dependencies.
`default_nettype none

package sbp_pkg;

  localparam int unsigned MAX_SEGMENTS_DEF = 16;

  // field widths
  localparam int unsigned PB_W    = 5;
  localparam int unsigned ALGN_W  = 17;
  localparam int unsigned RANGE_W = 32;
  localparam int unsigned LIMIT_W = 13;
  localparam int unsigned ID_W    = 16;
  localparam int unsigned DIM_W   = 16;
  localparam int unsigned PITCH_W = 20;
  localparam int unsigned ADDR_W  = 36;
  localparam int unsigned FILL_W  = 33;
  localparam int unsigned SEG_W   = 5;
  localparam int unsigned SEGN_W  = 4;
  localparam int unsigned RCNT_W  = 16;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  // shared unit width: covers base + range (37 bits) with a spare bit
  localparam int unsigned ALU_W = 38;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PIXEL_BYTES   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SEG_ALIGNMENT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SEG_RANGE     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LAYOUT_LIMIT  = 2'd3;

  // configuration reset values
  localparam logic [PB_W-1:0]    PB_RST    = 5'd4;
  localparam logic [ALGN_W-1:0]  ALGN_RST  = 17'd256;
  localparam logic [RANGE_W-1:0] RANGE_RST = 32'd65536;
  localparam logic [LIMIT_W-1:0] LIMIT_RST = 13'd4096;

  // minimum alignment of offsets and segment bases
  localparam logic [ALGN_W-1:0] MIN_ALIGN = 17'd4;

  typedef struct packed {
    logic [ALU_W-1:0] a;
    logic [ALU_W-1:0] b;
    logic             sub;
  } sbp_alu_op_t;

  typedef struct packed {
    logic [ALU_W-1:0] sum;
    logic             carry;
  } sbp_alu_res_t;

  typedef struct packed {
    logic               placed;
    logic [ID_W-1:0]    piece_tag;
    logic [SEGN_W-1:0]  segment_number;
    logic [31:0]        piece_offset;
    logic [31:0]        piece_bytes;
    logic [PITCH_W-1:0] line_stride;
    logic [LIMIT_W-1:0] placed_count;
    logic [RCNT_W-1:0]  rerouted_count;
    logic [ADDR_W-1:0]  buffer_end;
    logic [SEG_W-1:0]   segs_used;
  } sbp_res_t;

endpackage

`default_nettype wire

// File: hdl/sbp_if.sv
// Channel interfaces of the segmented buffer packer: piece input, result
// output and configuration write. Depends on sbp_pkg.
`default_nettype none

interface sbp_in_if;
  import sbp_pkg::*;
  logic             valid;
  logic             ready;
  logic             new_plan;
  logic [ID_W-1:0]  piece_id;
  logic [DIM_W-1:0] width;
  logic [DIM_W-1:0] height;
  modport source (output valid, new_plan, piece_id, width, height, input ready);
  modport sink   (input valid, new_plan, piece_id, width, height, output ready);
endinterface

interface sbp_out_if;
  import sbp_pkg::*;
  logic               valid;
  logic               ready;
  logic               placed;
  logic [ID_W-1:0]    piece_tag;
  logic [SEGN_W-1:0]  segment_number;
  logic [31:0]        piece_offset;
  logic [31:0]        piece_bytes;
  logic [PITCH_W-1:0] line_stride;
  logic [LIMIT_W-1:0] placed_count;
  logic [RCNT_W-1:0]  rerouted_count;
  logic [ADDR_W-1:0]  buffer_end;
  logic [SEG_W-1:0]   segs_used;
  modport source (output valid, placed, piece_tag, segment_number, piece_offset, piece_bytes,
                  line_stride, placed_count, rerouted_count, buffer_end, segs_used,
                  input ready);
  modport sink   (input valid, placed, piece_tag, segment_number, piece_offset, piece_bytes,
                  line_stride, placed_count, rerouted_count, buffer_end, segs_used,
                  output ready);
endinterface

interface sbp_cfg_if;
  import sbp_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: hdl/sbp_addsub.sv
// Shared add/subtract unit of the packer; every multiply step, alignment,
// remainder step and address sum goes through it. Depends on sbp_pkg.
`default_nettype none

module sbp_addsub (
  input  sbp_pkg::sbp_alu_op_t  op,
  output sbp_pkg::sbp_alu_res_t res
);
  import sbp_pkg::*;

  logic [ALU_W-1:0] b_eff;
  logic [ALU_W:0]   total;

  // subtract as a + ~b + 1; carry out high means no borrow (a >= b)
  assign b_eff = op.sub ? ~op.b : op.b;
  assign total = {1'b0, op.a} + {1'b0, b_eff} + (ALU_W+1)'(op.sub);

  assign res.sum   = total[ALU_W-1:0];
  assign res.carry = total[ALU_W];

endmodule

`default_nettype wire

// File: hdl/segmented_buffer_packer.sv
// Segmented buffer packer, top level. Depends on sbp_pkg, sbp_if, sbp_addsub.
// Opening a new segment adds a 37-step remainder for the base alignment.
// No new word is taken until the result has moved to the output register.
// One adder sets the pace.
// Reset (rst_n low, synchronous): registers back to defaults, plan cleared.
`default_nettype none

module segmented_buffer_packer #(
  parameter int unsigned MAX_SEGMENTS = sbp_pkg::MAX_SEGMENTS_DEF
) (
  input  wire        clk,
  input  wire        rst_n,
  sbp_cfg_if.sink    cfg_bus,
  sbp_in_if.sink     in_bus,
  sbp_out_if.source  out_bus
);
  import sbp_pkg::*;

  localparam logic [SEG_W-1:0] SEG_MAX = SEG_W'(MAX_SEGMENTS);
  localparam int unsigned V_W   = ADDR_W + 1;  // base + range
  localparam int unsigned CNT_W = 6;
  localparam int unsigned OFS_W = FILL_W + 1;  // aligned fill
  localparam int unsigned SUM_W = FILL_W + 2;  // aligned fill + size

  // sequencer states
  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_PITCH   = 4'd1;   // width * pixel_bytes, shift-add
  localparam logic [3:0] S_SIZE    = 4'd2;   // pitch * height, shift-add
  localparam logic [3:0] S_ALIGN4  = 4'd3;   // fill rounded up to 4, eligibility
  localparam logic [3:0] S_FILL    = 4'd4;   // offset + size
  localparam logic [3:0] S_DECIDE  = 4'd5;   // fits / new segment / reroute
  localparam logic [3:0] S_BASE    = 4'd6;   // old base + range
  localparam logic [3:0] S_MOD     = 4'd7;   // restoring remainder, bit a cycle
  localparam logic [3:0] S_ADJ     = 4'd8;   // align - remainder
  localparam logic [3:0] S_NEWBASE = 4'd9;   // base rounded up
  localparam logic [3:0] S_END     = 4'd10;  // commit totals, end address
  localparam logic [3:0] S_DONE    = 4'd11;  // hand result to output register

  // configuration
  logic [PB_W-1:0]    pb_r, pb_nxt;
  logic [ALGN_W-1:0]  algn_cfg_r, algn_cfg_nxt;
  logic [RANGE_W-1:0] range_r, range_nxt;
  logic [LIMIT_W-1:0] limit_r, limit_nxt;

  // sequencer
  logic [3:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  // per-piece working registers
  logic [ID_W-1:0]    id_r, id_nxt;
  logic [DIM_W-1:0]   mplier_r, mplier_nxt;
  logic [ADDR_W-1:0]  mcand_r, mcand_nxt;
  logic [ADDR_W-1:0]  acc_r, acc_nxt;
  logic [PITCH_W:0]   pitch_r, pitch_nxt;
  logic [ADDR_W-1:0]  size_r, size_nxt;
  logic [OFS_W-1:0]   offset_r, offset_nxt;
  logic [SUM_W-1:0]   fillc_r, fillc_nxt;
  logic               ok_r, ok_nxt;
  logic               placed_r, placed_nxt;
  logic [V_W-1:0]     v_r, v_nxt;
  logic [V_W-1:0]     vsh_r, vsh_nxt;
  logic [ALGN_W-1:0]  rem_r, rem_nxt;
  logic [ALGN_W-1:0]  adj_r, adj_nxt;

  // plan state
  logic [SEG_W-1:0]   cur_seg_r, cur_seg_nxt;
  logic [FILL_W-1:0]  fill_r, fill_nxt;
  logic [ADDR_W-1:0]  start_r, start_nxt;
  logic [LIMIT_W-1:0] ptot_r, ptot_nxt;
  logic [RCNT_W-1:0]  rtot_r, rtot_nxt;
  logic [ADDR_W-1:0]  hw_r, hw_nxt;

  // output register
  sbp_res_t out_r, out_nxt;
  logic     out_valid_r, out_valid_nxt;

  // shared unit
  sbp_alu_op_t  alu_op;
  sbp_alu_res_t alu_res;

  logic [ALGN_W-1:0] algn;      // effective segment alignment, at least 4
  logic [ALGN_W:0]   trial;     // remainder step operand
  logic [SEG_W-1:0]  seg_inc;
  logic [SEG_W-1:0]  seg_cnt;
  logic              in_acc;
  logic              cfg_acc;

  sbp_addsub u_alu (
    .op  (alu_op),
    .res (alu_res)
  );

  assign algn    = (algn_cfg_r > MIN_ALIGN) ? algn_cfg_r : MIN_ALIGN;
  assign trial   = {rem_r, vsh_r[V_W-1]};
  assign seg_inc = cur_seg_r + SEG_W'(1);
  // cur_seg never exceeds SEG_MAX, so seg_inc cannot wrap
  assign seg_cnt = (ptot_r == '0) ? '0 : ((seg_inc > SEG_MAX) ? SEG_MAX : seg_inc);

  assign in_bus.ready  = (state_r == S_IDLE);
  assign in_acc        = in_bus.valid && in_bus.ready;
  assign cfg_bus.ready = (state_r == S_IDLE);
  assign cfg_acc       = cfg_bus.valid && cfg_bus.ready;

  always_comb begin
    pb_nxt        = pb_r;
    algn_cfg_nxt  = algn_cfg_r;
    range_nxt     = range_r;
    limit_nxt     = limit_r;
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    id_nxt        = id_r;
    mplier_nxt    = mplier_r;
    mcand_nxt     = mcand_r;
    acc_nxt       = acc_r;
    pitch_nxt     = pitch_r;
    size_nxt      = size_r;
    offset_nxt    = offset_r;
    fillc_nxt     = fillc_r;
    ok_nxt        = ok_r;
    placed_nxt    = placed_r;
    v_nxt         = v_r;
    vsh_nxt       = vsh_r;
    rem_nxt       = rem_r;
    adj_nxt       = adj_r;
    cur_seg_nxt   = cur_seg_r;
    fill_nxt      = fill_r;
    start_nxt     = start_r;
    ptot_nxt      = ptot_r;
    rtot_nxt      = rtot_r;
    hw_nxt        = hw_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    alu_op        = '0;

    if (out_valid_r && out_bus.ready) begin
      out_valid_nxt = 1'b0;
    end

    // register writes land only while idle
    if (cfg_acc) begin
      case (cfg_bus.index)
        REG_PIXEL_BYTES:   pb_nxt       = cfg_bus.data[PB_W-1:0];
        REG_SEG_ALIGNMENT: algn_cfg_nxt = cfg_bus.data[ALGN_W-1:0];
        REG_SEG_RANGE:     range_nxt    = cfg_bus.data[RANGE_W-1:0];
        REG_LAYOUT_LIMIT:  limit_nxt    = cfg_bus.data[LIMIT_W-1:0];
        default: ;
      endcase
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          id_nxt     = in_bus.piece_id;
          mcand_nxt  = ADDR_W'(in_bus.width);
          mplier_nxt = DIM_W'(pb_r);
          acc_nxt    = '0;
          cnt_nxt    = '0;
          state_nxt  = S_PITCH;
          // height waits in v_r until the size multiply
          v_nxt      = V_W'(in_bus.height);
          if (in_bus.new_plan) begin
            cur_seg_nxt = '0;
            fill_nxt    = '0;
            start_nxt   = '0;
            ptot_nxt    = '0;
            rtot_nxt    = '0;
            hw_nxt      = '0;
          end
        end
      end

      S_PITCH: begin
        alu_op.a   = ALU_W'(acc_r);
        alu_op.b   = mplier_r[0] ? ALU_W'(mcand_r) : '0;
        acc_nxt    = alu_res.sum[ADDR_W-1:0];
        mcand_nxt  = mcand_r << 1;
        mplier_nxt = mplier_r >> 1;
        cnt_nxt    = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(PB_W - 1)) begin
          pitch_nxt  = alu_res.sum[PITCH_W:0];
          // a pitch above 20 bits reroutes, so its low bits suffice here
          mcand_nxt  = ADDR_W'(alu_res.sum[PITCH_W-1:0]);
          mplier_nxt = v_r[DIM_W-1:0];
          acc_nxt    = '0;
          cnt_nxt    = '0;
          state_nxt  = S_SIZE;
        end
      end

      S_SIZE: begin
        alu_op.a   = ALU_W'(acc_r);
        alu_op.b   = mplier_r[0] ? ALU_W'(mcand_r) : '0;
        acc_nxt    = alu_res.sum[ADDR_W-1:0];
        mcand_nxt  = mcand_r << 1;
        mplier_nxt = mplier_r >> 1;
        cnt_nxt    = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(DIM_W - 1)) begin
          size_nxt  = alu_res.sum[ADDR_W-1:0];
          state_nxt = S_ALIGN4;
        end
      end

      S_ALIGN4: begin
        alu_op.a   = ALU_W'(fill_r);
        alu_op.b   = ALU_W'(3);
        offset_nxt = {alu_res.sum[OFS_W-1:2], 2'b00};
        ok_nxt     = (cur_seg_r < SEG_MAX) && (pb_r != '0) && (range_r != '0) &&
                     !pitch_r[PITCH_W] && (size_r <= ADDR_W'(range_r)) &&
                     (ptot_r < limit_r);
        state_nxt  = S_FILL;
      end

      S_FILL: begin
        alu_op.a  = ALU_W'(offset_r);
        alu_op.b  = ALU_W'(size_r);
        fillc_nxt = alu_res.sum[SUM_W-1:0];
        state_nxt = S_DECIDE;
      end

      S_DECIDE: begin
        // offset + size > range covers both "offset past range" and
        // "size past the room left"
        if (!ok_r) begin
          placed_nxt = 1'b0;
          state_nxt  = S_END;
        end else if (fillc_r > SUM_W'(range_r)) begin
          if (seg_inc >= SEG_MAX) begin
            cur_seg_nxt = SEG_MAX;
            placed_nxt  = 1'b0;
            state_nxt   = S_END;
          end else begin
            cur_seg_nxt = seg_inc;
            offset_nxt  = '0;
            fillc_nxt   = SUM_W'(size_r);
            placed_nxt  = 1'b1;
            state_nxt   = S_BASE;
          end
        end else begin
          placed_nxt = 1'b1;
          state_nxt  = S_END;
        end
      end

      S_BASE: begin
        alu_op.a  = ALU_W'(start_r);
        alu_op.b  = ALU_W'(range_r);
        v_nxt     = alu_res.sum[V_W-1:0];
        vsh_nxt   = alu_res.sum[V_W-1:0];
        rem_nxt   = '0;
        cnt_nxt   = '0;
        state_nxt = S_MOD;
      end

      S_MOD: begin
        alu_op.a   = ALU_W'(trial);
        alu_op.b   = ALU_W'(algn);
        alu_op.sub = 1'b1;
        rem_nxt    = alu_res.carry ? alu_res.sum[ALGN_W-1:0] : trial[ALGN_W-1:0];
        vsh_nxt    = vsh_r << 1;
        cnt_nxt    = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(V_W - 1)) begin
          state_nxt = S_ADJ;
        end
      end

      S_ADJ: begin
        alu_op.a   = ALU_W'(algn);
        alu_op.b   = ALU_W'(rem_r);
        alu_op.sub = 1'b1;
        adj_nxt    = (rem_r == '0) ? '0 : alu_res.sum[ALGN_W-1:0];
        state_nxt  = S_NEWBASE;
      end

      S_NEWBASE: begin
        alu_op.a  = ALU_W'(v_r);
        alu_op.b  = ALU_W'(adj_r);
        start_nxt = alu_res.sum[ADDR_W-1:0];
        state_nxt = S_END;
      end

      S_END: begin
        alu_op.a = ALU_W'(start_r);
        alu_op.b = ALU_W'(fillc_r);
        if (placed_r) begin
          fill_nxt = fillc_r[FILL_W-1:0];
          ptot_nxt = ptot_r + LIMIT_W'(1);
          if (alu_res.sum > ALU_W'(hw_r)) begin
            hw_nxt = alu_res.sum[ADDR_W-1:0];
          end
        end else if (rtot_r != '1) begin
          rtot_nxt = rtot_r + RCNT_W'(1);
        end
        state_nxt = S_DONE;
      end

      S_DONE: begin
        if (!out_valid_r || out_bus.ready) begin
          out_nxt.placed         = placed_r;
          out_nxt.piece_tag      = id_r;
          out_nxt.segment_number = placed_r ? cur_seg_r[SEGN_W-1:0] : '0;
          out_nxt.piece_offset   = placed_r ? offset_r[31:0] : '0;
          out_nxt.piece_bytes    = placed_r ? size_r[31:0] : '0;
          out_nxt.line_stride    = pitch_r[PITCH_W-1:0];
          out_nxt.placed_count   = ptot_r;
          out_nxt.rerouted_count = rtot_r;
          out_nxt.buffer_end     = hw_r;
          out_nxt.segs_used      = seg_cnt;
          out_valid_nxt          = 1'b1;
          state_nxt              = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pb_r        <= PB_RST;
      algn_cfg_r  <= ALGN_RST;
      range_r     <= RANGE_RST;
      limit_r     <= LIMIT_RST;
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      cur_seg_r   <= '0;
      fill_r      <= '0;
      start_r     <= '0;
      ptot_r      <= '0;
      rtot_r      <= '0;
      hw_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pb_r        <= pb_nxt;
      algn_cfg_r  <= algn_cfg_nxt;
      range_r     <= range_nxt;
      limit_r     <= limit_nxt;
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      cur_seg_r   <= cur_seg_nxt;
      fill_r      <= fill_nxt;
      start_r     <= start_nxt;
      ptot_r      <= ptot_nxt;
      rtot_r      <= rtot_nxt;
      hw_r        <= hw_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    id_r     <= id_nxt;
    mplier_r <= mplier_nxt;
    mcand_r  <= mcand_nxt;
    acc_r    <= acc_nxt;
    pitch_r  <= pitch_nxt;
    size_r   <= size_nxt;
    offset_r <= offset_nxt;
    fillc_r  <= fillc_nxt;
    ok_r     <= ok_nxt;
    placed_r <= placed_nxt;
    v_r      <= v_nxt;
    vsh_r    <= vsh_nxt;
    rem_r    <= rem_nxt;
    adj_r    <= adj_nxt;
    out_r    <= out_nxt;
  end

  assign out_bus.valid          = out_valid_r;
  assign out_bus.placed         = out_r.placed;
  assign out_bus.piece_tag      = out_r.piece_tag;
  assign out_bus.segment_number = out_r.segment_number;
  assign out_bus.piece_offset   = out_r.piece_offset;
  assign out_bus.piece_bytes    = out_r.piece_bytes;
  assign out_bus.line_stride    = out_r.line_stride;
  assign out_bus.placed_count   = out_r.placed_count;
  assign out_bus.rerouted_count = out_r.rerouted_count;
  assign out_bus.buffer_end     = out_r.buffer_end;
  assign out_bus.segs_used      = out_r.segs_used;

endmodule

`default_nettype wire

// File: test/segmented_buffer_packer_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for segmented_buffer_packer: pieces go in through the input
// channel, each result word is predicted on acceptance and checked on arrival.
// Depends on sbp_pkg, the channel interfaces of sbp_if and the packer RTL.

module segmented_buffer_packer_tb;
  import sbp_pkg::*;

  // Longest quiet stretch a correct run can show: the packer latency, a sender gap,
  // a receiver stall and the settle hold, with margin.
  localparam int unsigned WATCHDOG_LIMIT = 5000;
  localparam int unsigned SETTLE_CYCLES  = 100;
  localparam logic [SEG_W-1:0] SEG_LIMIT = SEG_W'(MAX_SEGMENTS_DEF);
  localparam logic [63:0]      PITCH_MAX = 64'h0000_0000_000F_FFFF;

  typedef struct packed {
    logic             new_plan;
    logic [ID_W-1:0]  piece_id;
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
  } piece_t;

  logic clk = 1'b0;
  logic rst_n;

  sbp_in_if  in_if ();
  sbp_out_if out_if ();
  sbp_cfg_if cfg_if ();

  segmented_buffer_packer uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg_bus (cfg_if),
    .in_bus  (in_if),
    .out_bus (out_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow of the register file, updated as each write is accepted.
  logic [PB_W-1:0]    pix_bytes;
  logic [ALGN_W-1:0]  base_align;
  logic [RANGE_W-1:0] seg_range;
  logic [LIMIT_W-1:0] place_limit;

  // Running plan state of the packer as the bench sees it.
  logic [SEG_W-1:0]   seg_cur;
  logic [FILL_W-1:0]  seg_fill;
  logic [ADDR_W-1:0]  seg_base;
  logic [LIMIT_W-1:0] placed_n;
  logic [RCNT_W-1:0]  rerouted_n;
  logic [ADDR_W-1:0]  high_mark;

  piece_t   pieces_waiting[$];   // words not yet offered to the packer
  sbp_res_t placements_due[$];   // predicted result words, oldest first

  int unsigned mismatch_n = 0;
  int unsigned quiet_cycles = 0;
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  logic [31:0] stall_pat = '1;
  logic [5:0]  pat_age = '0;

  function automatic void clear_plan();
    seg_cur    = '0;
    seg_fill   = '0;
    seg_base   = '0;
    placed_n   = '0;
    rerouted_n = '0;
    high_mark  = '0;
  endfunction

  function automatic logic [63:0] round_up(logic [63:0] v, logic [63:0] a);
    logic [63:0] r;
    if (a <= 64'd1) return v;
    r = v % a;
    return (r == 64'd0) ? v : v + (a - r);
  endfunction

  // Places one piece against the shadow state and returns the result word the
  // packer owes for it.
  function automatic sbp_res_t place_piece(piece_t p);
    sbp_res_t         res;
    logic [63:0]      pitch, bytes, offs, aln, end_addr;
    logic [SEG_W-1:0] segs;
    logic             ok;
    if (p.new_plan) clear_plan();
    pitch = 64'(p.width) * 64'(pix_bytes);
    bytes = pitch * 64'(p.height);
    aln   = (base_align > MIN_ALIGN) ? 64'(base_align) : 64'(MIN_ALIGN);
    offs  = 64'd0;
    ok    = 1'b0;
    if (seg_cur < SEG_LIMIT && pix_bytes != '0 && seg_range != '0 && pitch <= PITCH_MAX &&
        bytes <= 64'(seg_range) && placed_n < place_limit) begin
      offs = round_up(64'(seg_fill), 64'(MIN_ALIGN));
      ok   = 1'b1;
      // no room left in this segment: open the next one, or give up past the last
      if (offs > 64'(seg_range) || bytes > 64'(seg_range) - offs) begin
        seg_cur = seg_cur + SEG_W'(1);
        if (seg_cur >= SEG_LIMIT) begin
          seg_cur = SEG_LIMIT;
          ok      = 1'b0;
        end else begin
          seg_base = ADDR_W'(round_up(64'(seg_base) + 64'(seg_range), aln));
          offs     = 64'd0;
        end
      end
    end
    if (ok) begin
      seg_fill = FILL_W'(offs + bytes);
      placed_n = placed_n + LIMIT_W'(1);
      end_addr = 64'(seg_base) + 64'(seg_fill);
      if (end_addr > 64'(high_mark)) high_mark = ADDR_W'(end_addr);
    end else if (rerouted_n != '1) begin
      rerouted_n = rerouted_n + RCNT_W'(1);
    end
    if (placed_n == '0) segs = '0;
    else if (seg_cur >= SEG_LIMIT) segs = SEG_LIMIT;
    else segs = seg_cur + SEG_W'(1);
    res.placed         = ok;
    res.piece_tag      = p.piece_id;
    res.segment_number = ok ? seg_cur[SEGN_W-1:0] : '0;
    res.piece_offset   = ok ? offs[31:0] : '0;
    res.piece_bytes    = ok ? bytes[31:0] : '0;
    res.line_stride    = pitch[PITCH_W-1:0];
    res.placed_count   = placed_n;
    res.rerouted_count = rerouted_n;
    res.buffer_end     = high_mark;
    res.segs_used      = segs;
    return res;
  endfunction

  // Random piece shaped by the current setting: mostly pieces sized against the
  // segment range so that plans fill several segments and often run out of
  // them, plus tiny pieces and fully random dimensions.
  function automatic piece_t make_piece();
    piece_t      p;
    int unsigned mode, rows;
    logic [63:0] target, unit, cols;
    p.new_plan = ($urandom_range(59, 0) == 0);
    p.piece_id = ID_W'($urandom);
    mode       = $urandom_range(9, 0);
    if (mode == 0) begin
      p.width  = DIM_W'($urandom);
      p.height = DIM_W'($urandom);
    end else if (mode <= 2) begin
      p.width  = DIM_W'($urandom_range(15, 0));
      p.height = DIM_W'($urandom_range(15, 0));
    end else begin
      rows     = $urandom_range(64, 1);
      // mode 9 aims at a piece that nearly fills a whole segment
      target   = (mode == 9) ? 64'(seg_range) : 64'($urandom_range(seg_range / 2, 0));
      unit     = 64'(rows) * ((pix_bytes == '0) ? 64'd1 : 64'(pix_bytes));
      cols     = target / unit;
      p.width  = (cols > 64'h0000_0000_0000_FFFF) ? '1 : cols[DIM_W-1:0];
      p.height = DIM_W'(rows);
    end
    return p;
  endfunction

  function automatic string diff_fields(sbp_res_t e, sbp_res_t a);
    string s;
    s = "";
    if (e.placed !== a.placed)                 s = {s, " placed"};
    if (e.piece_tag !== a.piece_tag)           s = {s, " piece_tag"};
    if (e.segment_number !== a.segment_number) s = {s, " segment_number"};
    if (e.piece_offset !== a.piece_offset)     s = {s, " piece_offset"};
    if (e.piece_bytes !== a.piece_bytes)       s = {s, " piece_bytes"};
    if (e.line_stride !== a.line_stride)       s = {s, " line_stride"};
    if (e.placed_count !== a.placed_count)     s = {s, " placed_count"};
    if (e.rerouted_count !== a.rerouted_count) s = {s, " rerouted_count"};
    if (e.buffer_end !== a.buffer_end)         s = {s, " buffer_end"};
    if (e.segs_used !== a.segs_used)           s = {s, " segs_used"};
    return s;
  endfunction

  function automatic string show_res(sbp_res_t r);
    return {$sformatf("placed=%0d tag=%h seg=%0d off=%h size=%h",
                      r.placed, r.piece_tag, r.segment_number, r.piece_offset,
                      r.piece_bytes),
            $sformatf(" pitch=%h pcnt=%0d rcnt=%0d total=%h segs=%0d",
                      r.line_stride, r.placed_count, r.rerouted_count, r.buffer_end,
                      r.segs_used)};
  endfunction

  task automatic queue_piece(input logic np, input logic [ID_W-1:0] id,
                             input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
    pieces_waiting.push_back(piece_t'{new_plan: np, piece_id: id, width: w, height: h});
  endtask

  // Blocks until every queued piece is in and every result word is out, then
  // holds off for the given number of cycles. Sampled on the falling edge so
  // that the driver and monitor have finished their work for the rising edge.
  task automatic settle(input int unsigned hold);
    @(negedge clk);
    while (pieces_waiting.size() != 0 || in_if.valid || placements_due.size() != 0)
      @(negedge clk);
    repeat (hold) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    cfg_if.valid <= 1'b0;
    case (idx)
      REG_PIXEL_BYTES:   pix_bytes   = val[PB_W-1:0];
      REG_SEG_ALIGNMENT: base_align  = val[ALGN_W-1:0];
      REG_SEG_RANGE:     seg_range   = val[RANGE_W-1:0];
      REG_LAYOUT_LIMIT:  place_limit = val[LIMIT_W-1:0];
      default: ;
    endcase
  endtask

  // Writes all four registers; unused upper data bits carry junk, which the
  // packer has to drop.
  task automatic set_config(input logic [PB_W-1:0] pb, input logic [ALGN_W-1:0] algn,
                            input logic [RANGE_W-1:0] rng, input logic [LIMIT_W-1:0] lim);
    logic [CFG_DATA_W-1:0] junk;
    junk = $urandom;
    write_reg(REG_PIXEL_BYTES,   {junk[CFG_DATA_W-1:PB_W], pb});
    write_reg(REG_SEG_ALIGNMENT, {junk[CFG_DATA_W-1:ALGN_W], algn});
    write_reg(REG_SEG_RANGE,     rng);
    write_reg(REG_LAYOUT_LIMIT,  {junk[CFG_DATA_W-1:LIMIT_W], lim});
  endtask

  task automatic run_phase(input int unsigned n);
    repeat (n) pieces_waiting.push_back(make_piece());
    settle(SETTLE_CYCLES);
  endtask

  // Piece driver: takes words off the pending queue in bursts, with idle gaps
  // between bursts. The prediction is made at the edge the word is accepted.
  always @(posedge clk) begin : piece_driver
    piece_t nxt;
    if (!rst_n) begin
      in_if.valid <= 1'b0;
      burst_left  = 0;
      gap_left    = 0;
    end else begin
      if (in_if.valid && in_if.ready)
        placements_due.push_back(place_piece(piece_t'{new_plan: in_if.new_plan,
                                                      piece_id: in_if.piece_id,
                                                      width:    in_if.width,
                                                      height:   in_if.height}));
      // slot is free once the word on the bus has gone, or if none is there
      if (!in_if.valid || in_if.ready) begin
        if (gap_left != 0) begin
          gap_left    = gap_left - 1;
          in_if.valid <= 1'b0;
        end else if (pieces_waiting.size() != 0) begin
          nxt = pieces_waiting.pop_front();
          in_if.valid    <= 1'b1;
          in_if.new_plan <= nxt.new_plan;
          in_if.piece_id <= nxt.piece_id;
          in_if.width    <= nxt.width;
          in_if.height   <= nxt.height;
          if (burst_left != 0) begin
            burst_left = burst_left - 1;
          end else begin
            // new burst; a third of the time no gap at all
            burst_left = $urandom_range(15, 0);
            gap_left   = ($urandom_range(2, 0) == 0) ? 0 : $urandom_range(100, 1);
          end
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: checks each accepted word against the oldest prediction.
  // Ready follows a rotating 32-bit pattern, swapped whenever the pattern age wraps,
  // between always ready, mostly ready, random and mostly stalled.
  always @(posedge clk) begin : result_monitor
    sbp_res_t got, want;
    if (rst_n && out_if.valid && out_if.ready) begin
      got = '{placed:         out_if.placed,
              piece_tag:      out_if.piece_tag,
              segment_number: out_if.segment_number,
              piece_offset:   out_if.piece_offset,
              piece_bytes:    out_if.piece_bytes,
              line_stride:    out_if.line_stride,
              placed_count:   out_if.placed_count,
              rerouted_count: out_if.rerouted_count,
              buffer_end:     out_if.buffer_end,
              segs_used:      out_if.segs_used};
      if (placements_due.size() == 0) begin
        mismatch_n = mismatch_n + 1;
        if (mismatch_n <= 10)
          $display("%0t: result word for piece %h with none expected", $time, got.piece_tag);
      end else begin
        want = placements_due.pop_front();
        if (want !== got) begin
          mismatch_n = mismatch_n + 1;
          if (mismatch_n <= 10) begin
            $display("%0t: piece %h wrong:%s", $time, want.piece_tag, diff_fields(want, got));
            $display("  expected %s", show_res(want));
            $display("  actual   %s", show_res(got));
          end
        end
      end
    end
    if (pat_age == '0) begin
      case ($urandom_range(3, 0))
        0:       stall_pat = '1;
        1:       stall_pat = $urandom | $urandom;
        2:       stall_pat = $urandom;
        default: stall_pat = ($urandom & $urandom) | 32'h1;
      endcase
    end else begin
      stall_pat = {stall_pat[0], stall_pat[31:1]};
    end
    pat_age       <= pat_age + 6'd1;
    out_if.ready  <= stall_pat[0];
  end

  // Watchdog: any accepted word on any channel restarts the count.
  always @(posedge clk) begin : watchdog
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no word accepted for %0d cycles", WATCHDOG_LIMIT);
      $display("segmented_buffer_packer_tb: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    int unsigned k;
    rst_n           = 1'b0;
    in_if.valid     = 1'b0;
    in_if.new_plan  = 1'b0;
    in_if.piece_id  = '0;
    in_if.width     = '0;
    in_if.height    = '0;
    cfg_if.valid    = 1'b0;
    cfg_if.index    = REG_PIXEL_BYTES;
    cfg_if.data     = '0;
    out_if.ready    = 1'b0;
    pix_bytes   = PB_RST;
    base_align  = ALGN_RST;
    seg_range   = RANGE_RST;
    place_limit = LIMIT_RST;
    clear_plan();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part at reset settings (4 bytes/pixel, 64 KiB segments).
    queue_piece(1'b1, 16'h0000, 16'd0, 16'd0);          // empty piece, fresh plan
    queue_piece(1'b0, 16'hFFFF, 16'd1, 16'd1);          // 4 bytes at offset 0
    queue_piece(1'b0, 16'h1234, 16'd3, 16'd1);          // 12 bytes at offset 4
    queue_piece(1'b0, 16'h8001, 16'hFFFF, 16'hFFFF);    // far too large: rerouted
    queue_piece(1'b0, 16'h7FFE, 16'hFFFF, 16'd0);       // widest pitch, zero size
    // full-segment pieces: each opens a new segment until all 16 are gone,
    // then the rest of the plan is rerouted
    for (k = 0; k < 17; k++)
      queue_piece(1'b0, ID_W'(16'h0100 + k), 16'd128, 16'd128);
    queue_piece(1'b1, 16'h00A5, 16'd0, 16'd1);          // new plan after exhaustion

    // Random part at reset settings, with one full drain in the middle.
    repeat (150) pieces_waiting.push_back(make_piece());
    settle(0);
    run_phase(150);

    set_config(5'd1,  17'd0,      32'hFFFF_FFFF, 13'h1FFF);  // huge segments, limit above 4096
    run_phase(200);
    set_config(5'd3,  17'd1,      32'd1000,      13'd4096);  // odd sizes, unaligned fill
    run_phase(200);
    set_config(5'd16, 17'd65536,  32'd65536,     13'd5);     // layout limit hit early
    run_phase(150);
    set_config(5'd31, 17'h1FFFF,  32'd200000,    13'd4096);  // pitch overflow, odd alignment
    run_phase(150);
    set_config(5'd0,  17'd4,      32'd65536,     13'd4096);  // zero pixel bytes
    run_phase(30);
    set_config(5'd2,  17'd3,      32'd0,         13'd4096);  // zero segment range
    run_phase(30);
    set_config(5'd4,  17'd256,    32'd1,         13'd4096);  // one-byte segments
    run_phase(30);
    set_config(5'd4,  17'd256,    32'd65536,     13'd0);     // nothing may be placed
    run_phase(30);
    set_config(5'd7,  17'd12345,  32'd30000,     13'd100);
    run_phase(150);
    repeat (3) begin
      set_config(PB_W'($urandom), ALGN_W'($urandom), RANGE_W'($urandom_range(200000, 1)),
                 LIMIT_W'($urandom));
      run_phase(50);
    end

    if (mismatch_n == 0)
      $display("segmented_buffer_packer_tb: clean");
    else
      $display("segmented_buffer_packer_tb: errors");
    $finish;
  end

endmodule

// File: files.f
hdl/sbp_pkg.sv
hdl/sbp_if.sv
hdl/sbp_addsub.sv
hdl/segmented_buffer_packer.sv
test/segmented_buffer_packer_tb.sv
